// File: hw/rtl/bole_pkg.sv
`default_nettype none

package bole_pkg;

    // Payload field widths
    localparam int OP_W    = 3;
    localparam int VAL_W   = 32;
    localparam int STAT_W  = 2;
    localparam int CNT_W   = 5;

    // Operation codes
    typedef enum logic [OP_W-1:0] {
        OP_PUSH_FRONT = 3'd0,
        OP_INSERT     = 3'd1,
        OP_POP        = 3'd2,
        OP_REMOVE     = 3'd3,
        OP_CLEAR      = 3'd4
    } op_t;

    // Result status codes
    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    // Controller states
    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FINISH,
        S_RESP
    } ctl_state_t;

    // Controller to datapath commands
    typedef struct packed {
        logic start;   // latch a new request
        logic issue;   // read the next entry
        logic finish;  // tail write and length update
        logic load;    // load the result register
    } ctl_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic scan_done;  // a read has been issued for every entry of the pass
        logic pend;       // a read is still returning
        logic out_free;   // result register can take a new result
    } dp_sts_t;

endpackage

`default_nettype wire

// File: hw/rtl/bole_if.sv
`default_nettype none

// Request channel
interface bole_in_if
    import bole_pkg::*;
;
    logic               valid;
    logic               ready;
    logic [OP_W-1:0]    op;
    logic [VAL_W-1:0]   value;

    modport source (output valid, output op, output value, input ready);
    modport sink (input valid, input op, input value, output ready);
endinterface

// Result channel
interface bole_out_if
    import bole_pkg::*;
;
    logic               valid;
    logic               ready;
    logic [STAT_W-1:0]  status;
    logic [VAL_W-1:0]   popped_value;
    logic [CNT_W-1:0]   removed_count;
    logic [CNT_W-1:0]   length_after;

    modport source (output valid, output status, output popped_value,
                    output removed_count, output length_after, input ready);
    modport sink (input valid, input status, input popped_value,
                  input removed_count, input length_after, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/bole_ram.sv
`default_nettype none

module bole_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/bole_ctrl.sv
`default_nettype none

module bole_ctrl
    import bole_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     in_valid,
    output logic          in_ready,
    input  wire dp_sts_t  sts,
    output ctl_cmd_t      cmd
);

    ctl_state_t state_reg, state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.start  = 1'b1;
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (!sts.scan_done)
                begin
                    cmd.issue = 1'b1;
                end
                else if (!sts.pend)
                begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                cmd.finish = 1'b1;
                state_next = S_RESP;
            end
            S_RESP:
            begin
                if (sts.out_free)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// File: hw/rtl/bole_datapath.sv
`default_nettype none

module bole_datapath
    import bole_pkg::*;
#(
    parameter int DEPTH = 16
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire ctl_cmd_t          cmd,
    output dp_sts_t                sts,
    input  wire logic [OP_W-1:0]   in_op,
    input  wire logic [VAL_W-1:0]  in_value,
    input  wire logic              out_ready,
    output logic                   out_valid,
    output logic [STAT_W-1:0]      out_status,
    output logic [VAL_W-1:0]       out_popped_value,
    output logic [CNT_W-1:0]       out_removed_count,
    output logic [CNT_W-1:0]       out_length_after
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
    localparam logic [CW-1:0] ONE_C   = CW'(1);

    // Request and pass state
    op_t             op_reg;
    logic [VAL_W-1:0] val_reg;
    status_t         stat_reg, stat_next;
    logic [CW-1:0]   len_reg;
    logic [CW-1:0]   lim_reg, lim_next;
    logic [CW-1:0]   rd_idx_reg;
    logic            rv_reg;
    logic [AW-1:0]   rpos_reg;
    logic [CW-1:0]   wr_ptr_reg;
    logic [CW-1:0]   rem_reg;
    logic [VAL_W-1:0] carry_reg;
    logic            ins_reg;
    logic [VAL_W-1:0] pop_reg;

    // Result register
    logic               out_valid_reg;
    logic [STAT_W-1:0]  out_status_reg;
    logic [VAL_W-1:0]   out_pop_reg;
    logic [CNT_W-1:0]   out_rem_reg;
    logic [CNT_W-1:0]   out_len_reg;

    // Entry memory ports
    logic             ram_we;
    logic [AW-1:0]    ram_waddr;
    logic [VAL_W-1:0] ram_wdata;
    logic [VAL_W-1:0] ram_rdata;

    // Per-entry decisions
    logic is_ins_op;
    logic take_slot;
    logic drop;

    bole_ram #(
        .WIDTH (VAL_W),
        .DEPTH (DEPTH)
    ) u_entries (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (cmd.issue),
        .raddr (rd_idx_reg[AW-1:0]),
        .rdata (ram_rdata)
    );

    // Status and pass length of a new request
    always_comb
    begin
        stat_next = ST_OK;
        lim_next  = '0;
        case (op_t'(in_op))
            OP_PUSH_FRONT, OP_INSERT:
            begin
                if (len_reg >= DEPTH_C)
                begin
                    stat_next = ST_FULL;
                end
                else
                begin
                    lim_next = len_reg;
                end
            end
            OP_POP:
            begin
                if (len_reg == '0)
                begin
                    stat_next = ST_EMPTY;
                end
                else
                begin
                    lim_next = len_reg;
                end
            end
            OP_REMOVE:
            begin
                lim_next = len_reg;
            end
            default:
            begin
                lim_next = '0;
            end
        endcase
    end

    // Entry returned from memory: shift-in or compaction write; tail write at finish
    always_comb
    begin
        is_ins_op = (op_reg == OP_PUSH_FRONT) || (op_reg == OP_INSERT);
        take_slot = !ins_reg && ((op_reg == OP_PUSH_FRONT) ||
                    ($signed(ram_rdata) >= $signed(val_reg)));
        drop      = (op_reg == OP_POP) ? (rpos_reg == '0) : (ram_rdata == val_reg);
        ram_we    = 1'b0;
        ram_waddr = rpos_reg;
        ram_wdata = ram_rdata;
        if (rv_reg)
        begin
            if (is_ins_op)
            begin
                if (take_slot)
                begin
                    ram_we    = 1'b1;
                    ram_wdata = val_reg;
                end
                else if (ins_reg)
                begin
                    ram_we    = 1'b1;
                    ram_wdata = carry_reg;
                end
            end
            else if (!drop)
            begin
                ram_we    = 1'b1;
                ram_waddr = wr_ptr_reg[AW-1:0];
            end
        end
        else if (cmd.finish && (stat_reg == ST_OK) && is_ins_op)
        begin
            // last entry moves back one, or the value lands at the end
            ram_we    = 1'b1;
            ram_waddr = len_reg[AW-1:0];
            ram_wdata = ins_reg ? carry_reg : val_reg;
        end
    end

    // Length survives between requests
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg       <= '0;
            rv_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            rv_reg <= cmd.issue;
            if (cmd.finish && (stat_reg == ST_OK))
            begin
                case (op_reg)
                    OP_PUSH_FRONT, OP_INSERT: len_reg <= len_reg + ONE_C;
                    OP_POP, OP_REMOVE:        len_reg <= wr_ptr_reg;
                    OP_CLEAR:                 len_reg <= '0;
                    default:                  len_reg <= len_reg;
                endcase
            end
            if (cmd.load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Pass registers
    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            op_reg     <= op_t'(in_op);
            val_reg    <= in_value;
            stat_reg   <= stat_next;
            lim_reg    <= lim_next;
            rd_idx_reg <= '0;
            wr_ptr_reg <= '0;
            rem_reg    <= '0;
            ins_reg    <= 1'b0;
            pop_reg    <= '0;
        end
        else
        begin
            if (cmd.issue)
            begin
                rd_idx_reg <= rd_idx_reg + ONE_C;
                rpos_reg   <= rd_idx_reg[AW-1:0];
            end
            if (rv_reg)
            begin
                if (is_ins_op)
                begin
                    if (take_slot || ins_reg)
                    begin
                        carry_reg <= ram_rdata;
                        ins_reg   <= 1'b1;
                    end
                end
                else if (drop)
                begin
                    rem_reg <= rem_reg + ONE_C;
                    if (op_reg == OP_POP)
                    begin
                        pop_reg <= ram_rdata;
                    end
                end
                else
                begin
                    wr_ptr_reg <= wr_ptr_reg + ONE_C;
                end
            end
        end
        if (cmd.load)
        begin
            out_status_reg <= stat_reg;
            out_pop_reg    <= pop_reg;
            out_rem_reg    <= (op_reg == OP_REMOVE) ? CNT_W'(rem_reg) : '0;
            out_len_reg    <= CNT_W'(len_reg);
        end
    end

    assign sts.scan_done = (rd_idx_reg == lim_reg);
    assign sts.pend      = rv_reg;
    assign sts.out_free  = !out_valid_reg || out_ready;

    assign out_valid         = out_valid_reg;
    assign out_status        = out_status_reg;
    assign out_popped_value  = out_pop_reg;
    assign out_removed_count = out_rem_reg;
    assign out_length_after  = out_len_reg;

endmodule

`default_nettype wire

// File: hw/rtl/bounded_ordered_list_engine_top.sv
`default_nettype none

// Channel  Dir  Payload                                              Accept
// req      in   op[2:0], value[31:0]                                 valid & ready
// rsp      out  status[1:0], popped_value[31:0], removed_count[4:0], valid & ready
//               length_after[4:0]
//
// One request at a time. Clear, unused codes, full inserts and empty pops
// read no entries; the other operations walk the list once through the
// single read port of the entry memory. A new request is taken while a
// result still waits in the output register. Reset empties the list; the
// entry memory needs no clearing pass.

module bounded_ordered_list_engine_top
    import bole_pkg::*;
#(
    parameter int DEPTH = 16
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    bole_in_if.sink    req,
    bole_out_if.source rsp
);

    ctl_cmd_t cmd;
    dp_sts_t  sts;

    bole_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_ready (req.ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    bole_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd               (cmd),
        .sts               (sts),
        .in_op             (req.op),
        .in_value          (req.value),
        .out_ready         (rsp.ready),
        .out_valid         (rsp.valid),
        .out_status        (rsp.status),
        .out_popped_value  (rsp.popped_value),
        .out_removed_count (rsp.removed_count),
        .out_length_after  (rsp.length_after)
    );

endmodule

`default_nettype wire

// File: sim/bole_list_checker.sv
`timescale 1ns / 1ps

// Watches both channels, keeps a shadow copy of the ordered list, and
// compares every result against the oldest outstanding prediction.
module bole_list_checker
    import bole_pkg::*;
#(
    parameter int DEPTH = 16
) (
    input  logic clk,
    input  logic rst_n,
    bole_in_if   req,
    bole_out_if  rsp,
    output int   mismatch_count,
    output int   results_owed
);

    typedef struct packed {
        status_t           status;
        logic [VAL_W-1:0]  popped_value;
        logic [CNT_W-1:0]  removed_count;
        logic [CNT_W-1:0]  length_after;
    } list_result_t;

    localparam int REPORT_MAX = 10;

    // Shadow of the list contents, head at index 0
    logic [VAL_W-1:0] shadow_list [DEPTH];
    int               shadow_len;
    list_result_t     expected_results [$];

    // Apply one request to the shadow list and return the result it yields
    function automatic list_result_t apply_list_op(input logic [OP_W-1:0] op,
                                                   input logic [VAL_W-1:0] value);
        list_result_t r;
        int pos;
        int keep;
        r = '{status: ST_OK, popped_value: '0, removed_count: '0, length_after: '0};
        case (op)
            OP_PUSH_FRONT, OP_INSERT:
            begin
                if (shadow_len >= DEPTH)
                begin
                    r.status = ST_FULL;
                end
                else
                begin
                    pos = 0;
                    // ordered insert goes before the first entry >= value
                    if (op == OP_INSERT)
                    begin
                        while (pos < shadow_len && $signed(shadow_list[pos]) < $signed(value))
                            pos++;
                    end
                    for (int i = shadow_len; i > pos; i--)
                        shadow_list[i] = shadow_list[i-1];
                    shadow_list[pos] = value;
                    shadow_len++;
                end
            end
            OP_POP:
            begin
                if (shadow_len == 0)
                begin
                    r.status = ST_EMPTY;
                end
                else
                begin
                    r.popped_value = shadow_list[0];
                    for (int i = 1; i < shadow_len; i++)
                        shadow_list[i-1] = shadow_list[i];
                    shadow_len--;
                end
            end
            OP_REMOVE:
            begin
                // compact the survivors in order
                keep = 0;
                for (int i = 0; i < shadow_len; i++)
                begin
                    if (shadow_list[i] == value)
                        r.removed_count++;
                    else
                    begin
                        shadow_list[keep] = shadow_list[i];
                        keep++;
                    end
                end
                shadow_len = keep;
            end
            OP_CLEAR:
            begin
                shadow_len = 0;
            end
            default:
            begin
                // spare codes leave the list alone
            end
        endcase
        r.length_after = CNT_W'(shadow_len);
        return r;
    endfunction

    // Responses are matched before the same-edge request is predicted
    always @(posedge clk or negedge rst_n)
    begin
        list_result_t got;
        list_result_t want;
        if (!rst_n)
        begin
            shadow_len = 0;
            expected_results.delete();
            mismatch_count = 0;
            results_owed = 0;
        end
        else
        begin
            if (rsp.valid && rsp.ready)
            begin
                got.status        = status_t'(rsp.status);
                got.popped_value  = rsp.popped_value;
                got.removed_count = rsp.removed_count;
                got.length_after  = rsp.length_after;
                if (expected_results.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_MAX)
                        $display("%0t: unexpected result st=%0d pop=%h rm=%0d len=%0d",
                                 $realtime, got.status, got.popped_value,
                                 got.removed_count, got.length_after);
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (got.status !== want.status || got.popped_value !== want.popped_value
                        || got.removed_count !== want.removed_count
                        || got.length_after !== want.length_after)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= REPORT_MAX)
                            $display({"%0t: result mismatch exp st=%0d pop=%h rm=%0d len=%0d",
                                      " got st=%0d pop=%h rm=%0d len=%0d"},
                                     $realtime, want.status, want.popped_value,
                                     want.removed_count, want.length_after,
                                     got.status, got.popped_value,
                                     got.removed_count, got.length_after);
                    end
                end
            end
            if (req.valid && req.ready)
                expected_results.push_back(apply_list_op(req.op, req.value));
            results_owed = expected_results.size();
        end
    end

endmodule

// File: sim/bounded_ordered_list_engine_top_tb.sv
`timescale 1ns / 1ps

module bounded_ordered_list_engine_top_tb;
    import bole_pkg::*;

    localparam int DEPTH = 16;
    localparam logic [OP_W-1:0] OP_FIRST_SPARE = 3'd5;
    localparam logic [OP_W-1:0] OP_LAST_SPARE  = 3'd7;
    localparam logic [VAL_W-1:0] VAL_MIN = 32'h8000_0000;
    localparam logic [VAL_W-1:0] VAL_MAX = 32'h7fff_ffff;
    localparam int ITEMS_PER_PHASE = 400;
    localparam int LONG_HOLD = 300;
    localparam int DRAIN_LIMIT = 20000;
    localparam int TAIL_CYCLES = 20;

    logic clk;
    logic rst_n;
    int   send_idle_pct;
    int   rsp_idle_pct;
    int   hold_asks;
    int   mismatch_count;
    int   results_owed;

    bole_in_if  req_ch ();
    bole_out_if rsp_ch ();

    bounded_ordered_list_engine_top #(.DEPTH(DEPTH)) u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    bole_list_checker #(.DEPTH(DEPTH)) u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .req            (req_ch),
        .rsp            (rsp_ch),
        .mismatch_count (mismatch_count),
        .results_owed   (results_owed)
    );

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Hard stop in case the block hangs
    initial
    begin
        #5_000_000;
        $display("tb: failure");
        $finish;
    end

    // Result side: random back-pressure plus long hold-offs on request
    initial
    begin
        int hold_left;
        int hold_done;
        hold_left = 0;
        hold_done = 0;
        rsp_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                rsp_ch.ready = 1'b0;
                hold_left--;
            end
            else if (hold_done != hold_asks)
            begin
                hold_done = hold_asks;
                hold_left = LONG_HOLD - 1;
                rsp_ch.ready = 1'b0;
            end
            else
                rsp_ch.ready = ($urandom_range(99) >= rsp_idle_pct);
        end
    end

    // Present one request, idling first at the current rate; returns at the
    // falling edge after it is taken
    task automatic send_request(input logic [OP_W-1:0] op, input logic [VAL_W-1:0] value);
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_ch.valid = 1'b0;
            @(negedge clk);
        end
        req_ch.valid = 1'b1;
        req_ch.op    = op;
        req_ch.value = value;
        do @(posedge clk); while (!req_ch.ready);
        @(negedge clk);
    endtask

    // Operand mix: small values collide often, extremes and full range too
    function automatic logic [VAL_W-1:0] pick_operand();
        int sel;
        sel = $urandom_range(99);
        if (sel < 50)
            return VAL_W'($signed($urandom_range(8)) - 4);
        else if (sel < 70)
        begin
            case ($urandom_range(3))
                0: return VAL_MIN;
                1: return VAL_MAX;
                2: return VAL_MIN + 1;
                default: return VAL_MAX - 1;
            endcase
        end
        return $urandom;
    endfunction

    // Stimulus
    initial
    begin
        int sent;
        int burst;
        int sel;
        int wait_n;
        rst_n = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.op    = OP_PUSH_FRONT;
        req_ch.value = '0;
        send_idle_pct = 10;
        rsp_idle_pct  = 78;
        hold_asks = 0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: empty list, spare codes, extremes, duplicates, removes
        send_request(OP_POP, '0);
        send_request(OP_CLEAR, '0);
        send_request(OP_REMOVE, 32'd5);
        send_request(OP_FIRST_SPARE, VAL_MAX);
        send_request(OP_FIRST_SPARE + 3'd1, VAL_MIN);
        send_request(OP_LAST_SPARE, '1);
        send_request(OP_PUSH_FRONT, VAL_MIN);
        send_request(OP_PUSH_FRONT, VAL_MAX);
        send_request(OP_INSERT, '0);
        send_request(OP_INSERT, '1);
        send_request(OP_INSERT, '0);
        send_request(OP_INSERT, VAL_MAX);
        send_request(OP_INSERT, VAL_MIN);
        send_request(OP_REMOVE, 32'd12345);
        send_request(OP_REMOVE, '0);
        send_request(OP_POP, '0);
        send_request(OP_REMOVE, VAL_MAX);
        send_request(OP_POP, '0);
        send_request(OP_CLEAR, '0);
        send_request(OP_POP, '0);

        // Random phases: sender idles lightly, then receiver, then neither
        for (int phase = 0; phase < 3; phase++)
        begin
            send_idle_pct = (phase == 0) ? 10 : (phase == 1) ? 78 : 0;
            rsp_idle_pct  = (phase == 0) ? 78 : (phase == 1) ? 10 : 0;
            sent = 0;
            while (sent < ITEMS_PER_PHASE)
            begin
                // receiver stalls for a long time while requests keep coming
                if (phase == 0 && sent >= 100 && hold_asks == 0)
                    hold_asks++;
                // sender goes quiet until every result is back
                if (phase == 1 && sent >= 200 && sent < 220)
                begin
                    req_ch.valid = 1'b0;
                    @(negedge clk);
                    while (results_owed != 0)
                        @(negedge clk);
                    sent = 220;
                end
                sel = $urandom_range(99);
                if (sel < 25)
                begin
                    // fill run of 4 to 20 inserts, long enough to overflow from a short list
                    burst = $urandom_range(20, 4);
                    for (int i = 0; i < burst; i++)
                        send_request($urandom_range(1) ? OP_INSERT : OP_PUSH_FRONT,
                                     pick_operand());
                    sent += burst;
                end
                else if (sel < 40)
                begin
                    // drain run, may underflow
                    burst = $urandom_range(20, 2);
                    for (int i = 0; i < burst; i++)
                        send_request(OP_POP, $urandom);
                    sent += burst;
                end
                else if (sel < 60)
                begin
                    send_request(OP_REMOVE, pick_operand());
                    sent++;
                end
                else if (sel < 64)
                begin
                    send_request(OP_CLEAR, $urandom);
                    sent++;
                end
                else if (sel < 69)
                begin
                    // spare codes are ignored and not counted
                    send_request(OP_W'($urandom_range(OP_LAST_SPARE, OP_FIRST_SPARE)),
                                 $urandom);
                end
                else
                begin
                    send_request(OP_W'($urandom_range(OP_CLEAR, OP_PUSH_FRONT)),
                                 pick_operand());
                    sent++;
                end
            end
        end

        // Drain outstanding results, then allow the pipeline to settle
        req_ch.valid = 1'b0;
        wait_n = 0;
        while (results_owed != 0 && wait_n < DRAIN_LIMIT)
        begin
            @(negedge clk);
            wait_n++;
        end
        repeat (TAIL_CYCLES) @(negedge clk);

        if (mismatch_count == 0 && results_owed == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// File: sim.f
hw/rtl/bole_pkg.sv
hw/rtl/bole_if.sv
hw/rtl/bole_ram.sv
hw/rtl/bole_ctrl.sv
hw/rtl/bole_datapath.sv
hw/rtl/bounded_ordered_list_engine_top.sv
sim/bole_list_checker.sv
sim/bounded_ordered_list_engine_top_tb.sv
